// ----- hdl/escc_pkg.sv -----
package escc_pkg;

  localparam logic [11:0] EPOCH_YEAR    = 12'd1970;
  localparam logic [8:0]  DAYS_COMMON   = 9'd365;
  localparam logic [8:0]  DAYS_LEAP     = 9'd366;
  localparam logic [4:0]  DAYS_FEB      = 5'd28;
  localparam logic [4:0]  DAYS_FEB_LEAP = 5'd29;
  localparam logic [4:0]  DAYS_SHORT    = 5'd30;
  localparam logic [4:0]  DAYS_LONG     = 5'd31;
  localparam logic [3:0]  MONTH_FEB     = 4'd2;
  localparam logic [3:0]  MONTH_JUL     = 4'd7;
  localparam logic [3:0]  MONTHS        = 4'd12;
  localparam logic [16:0] SEC_PER_DAY   = 17'd86400;
  localparam logic [16:0] SEC_PER_HOUR  = 17'd3600;
  localparam logic [16:0] SEC_PER_MIN   = 17'd60;
  // floor(y / 100) == (y * RECIP_100) >> RECIP_SHIFT for every 12-bit y
  localparam logic [12:0] RECIP_100     = 13'd5243;
  localparam int          RECIP_SHIFT   = 19;
  localparam logic [11:0] CENTURY       = 12'd100;
  // 86400 = 675 << 7: floor(x / 675) == (x * RECIP_675) >> 35 for every 25-bit x
  localparam logic [25:0] RECIP_675     = 26'd50903317;
  // 3600 = 225 << 4: floor(x / 225) == (x * RECIP_225) >> 21 for every 13-bit x
  localparam logic [13:0] RECIP_225     = 14'd9321;
  // 60 = 15 << 2: floor(x / 15) == (x * RECIP_15) >> 14 for every 10-bit x
  localparam logic [10:0] RECIP_15      = 11'd1093;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef enum logic {
    OP_TO_DATE,
    OP_TO_SECONDS
  } op_t;

  // Gregorian leap test on a full 12-bit year
  function automatic logic is_leap(input logic [11:0] y);
    logic [24:0] prod;
    logic [5:0]  q;
    logic [11:0] q100;
    logic        leap;
    prod = 25'(y) * 25'(RECIP_100);
    q    = prod[24:RECIP_SHIFT];
    q100 = 12'(q) * CENTURY;
    if (y == q100) begin
      leap = (q[1:0] == 2'b00);
    end else begin
      leap = (y[1:0] == 2'b00);
    end
    return leap;
  endfunction

  // Length of month m; months past July alternate the other way round
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    if (m == MONTH_FEB) begin
      len = leap ? DAYS_FEB_LEAP : DAYS_FEB;
    end else if (m <= MONTH_JUL) begin
      len = m[0] ? DAYS_LONG : DAYS_SHORT;
    end else begin
      len = m[0] ? DAYS_SHORT : DAYS_LONG;
    end
    return len;
  endfunction

endpackage

// ----- hdl/escc_alu.sv -----
module escc_alu (
  input  logic [31:0]       a,
  input  logic [31:0]       b,
  input  escc_pkg::alu_op_t op,
  output logic [31:0]       y,
  output logic              ge
);

  logic        sub;
  logic [31:0] b_eff;
  logic [32:0] sum;

  assign sub   = (op == escc_pkg::ALU_SUB);
  assign b_eff = sub ? ~b : b;
  assign sum   = {1'b0, a} + {1'b0, b_eff} + 33'(sub);
  assign y     = sum[31:0];
  // no borrow on a subtract means a >= b
  assign ge    = sub & sum[32];

endmodule

// ----- hdl/epoch_seconds_calendar_converter.sv -----
// Converts between a 32-bit count of seconds since 1970-01-01 00:00:00 and a
// Gregorian date and time, one item at a time, with one shared 32-bit
// add/subtract unit stepped by a small sequencer. Operation 0 (tuser = 0)
// first splits the count: days, hours and minutes each take one reciprocal
// multiply for the quotient and one shared subtract for the remainder. Then
// it takes off one whole year at a time from 1970 on, and then one month at
// a time up to the result month. Operation 1 (tuser = 1) builds the count:
// it adds one year at a time from 1970 up to in_year, one month at a time
// before in_month, then the day, multiplies by 86400 and adds the time of
// day. Dates are not checked, and a year up to 4095 simply makes the year
// loop run longer. The year and month loops set the rate.
// Input is taken only while the sequencer is idle; a finished result sits in
// an output register, so the next item may be taken while it waits, and the
// sequencer then holds in its last step until that register is free.
module epoch_seconds_calendar_converter (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // epoch_seconds[31:0], in_year[43:32], in_month[47:44], in_day[52:48],
  // in_hour[57:53], in_minute[63:58], in_second[69:64], zero[71:70]
  input  logic [71:0] s_axis_tdata,
  // operation[0]
  input  logic [0:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_seconds[31:0], out_year[43:32], out_month[47:44], out_day[52:48],
  // out_hour[57:53], out_minute[63:58], out_second[69:64], zero[71:70]
  output logic [71:0] m_axis_tdata
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_YEAR,
    ST_MONTH,
    ST_DAYADD,
    ST_MUL,
    ST_SOD,
    ST_FIN
  } state_t;

  typedef enum logic [2:0] {
    DIV_DAY_Q,
    DIV_DAY_R,
    DIV_HOUR_Q,
    DIV_HOUR_R,
    DIV_MIN_Q,
    DIV_MIN_R
  } div_stage_t;

  state_t        state;
  div_stage_t    dstage;
  escc_pkg::op_t op;
  logic [31:0] acc;
  logic [24:0] days;
  logic [11:0] year;
  logic        leap;
  logic [3:0]  month;
  logic [11:0] in_year;
  logic [3:0]  in_month;
  logic        mleap;
  logic [5:0]  dm1;
  logic [16:0] sod;
  logic [4:0]  day;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  sec;

  logic [31:0]       alu_a;
  logic [31:0]       alu_b;
  escc_pkg::alu_op_t alu_op;
  logic [31:0]       alu_y;
  logic              alu_ge;

  logic [50:0] day_prod;
  logic [26:0] hour_prod;
  logic [20:0] min_prod;
  logic [31:0] div_back;
  logic [8:0]  ylen;
  logic [4:0]  mlen;
  logic [11:0] year_inc;
  logic [41:0] mul_full;
  logic [5:0]  s_dm1;
  logic [16:0] s_sod;
  logic [71:0] out_pack;

  escc_alu u_alu (
    .a  (alu_a),
    .b  (alu_b),
    .op (alu_op),
    .y  (alu_y),
    .ge (alu_ge)
  );

  assign s_axis_tready = (state == ST_IDLE);

  // quotients by reciprocal multiply on the pre-shifted dividend
  assign day_prod  = 51'(acc[31:7]) * 51'(escc_pkg::RECIP_675);
  assign hour_prod = 27'(acc[16:4]) * 27'(escc_pkg::RECIP_225);
  assign min_prod  = 21'(acc[11:2]) * 21'(escc_pkg::RECIP_15);

  // quotient times divisor, taken off by the shared unit for the remainder
  always_comb begin
    case (dstage)
      DIV_DAY_R:  div_back = 32'(days[15:0]) * 32'(escc_pkg::SEC_PER_DAY);
      DIV_HOUR_R: div_back = 32'(hour) * 32'(escc_pkg::SEC_PER_HOUR);
      default:    div_back = 32'(minute) * 32'(escc_pkg::SEC_PER_MIN);
    endcase
  end

  assign ylen      = leap ? escc_pkg::DAYS_LEAP : escc_pkg::DAYS_COMMON;
  assign mlen      = escc_pkg::month_len(month,
                       (op == escc_pkg::OP_TO_SECONDS) ? mleap : leap);
  assign year_inc  = year + 12'd1;
  assign mul_full  = 42'(days) * 42'(escc_pkg::SEC_PER_DAY);
  assign s_dm1     = {1'b0, s_axis_tdata[52:48]} - 6'd1;
  assign s_sod     = 17'(s_axis_tdata[57:53]) * escc_pkg::SEC_PER_HOUR
                   + 17'(s_axis_tdata[63:58]) * escc_pkg::SEC_PER_MIN
                   + 17'(s_axis_tdata[69:64]);

  always_comb begin
    alu_a  = 32'd0;
    alu_b  = 32'd0;
    alu_op = escc_pkg::ALU_SUB;
    case (state)
      ST_DIV: begin
        alu_a = acc;
        alu_b = div_back;
      end
      ST_YEAR: begin
        alu_a  = 32'(days);
        alu_b  = 32'(ylen);
        alu_op = (op == escc_pkg::OP_TO_SECONDS) ? escc_pkg::ALU_ADD : escc_pkg::ALU_SUB;
      end
      ST_MONTH: begin
        alu_a  = 32'(days);
        alu_b  = 32'(mlen);
        alu_op = (op == escc_pkg::OP_TO_SECONDS) ? escc_pkg::ALU_ADD : escc_pkg::ALU_SUB;
      end
      ST_DAYADD: begin
        alu_a  = 32'(days);
        alu_b  = {{26{dm1[5]}}, dm1};
        alu_op = escc_pkg::ALU_ADD;
      end
      ST_SOD: begin
        alu_a  = acc;
        alu_b  = 32'(sod);
        alu_op = escc_pkg::ALU_ADD;
      end
      default: begin
        alu_a = 32'd0;
      end
    endcase
  end

  always_comb begin
    if (op == escc_pkg::OP_TO_SECONDS) begin
      out_pack = {40'd0, acc};
    end else begin
      out_pack = {2'b00, sec, minute, hour, day, month, year, 32'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      // the finish step refills the output register itself
      if (m_axis_tvalid && m_axis_tready && state != ST_FIN) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            op       <= escc_pkg::op_t'(s_axis_tuser[0]);
            year     <= escc_pkg::EPOCH_YEAR;
            leap     <= escc_pkg::is_leap(escc_pkg::EPOCH_YEAR);
            month    <= 4'd1;
            days     <= 25'd0;
            in_year  <= s_axis_tdata[43:32];
            in_month <= s_axis_tdata[47:44];
            mleap    <= escc_pkg::is_leap(s_axis_tdata[43:32]);
            dm1      <= s_dm1;
            sod      <= s_sod;
            // count to date starts with the day division
            dstage   <= DIV_DAY_Q;
            acc      <= s_axis_tdata[31:0];
            state    <= (escc_pkg::op_t'(s_axis_tuser[0]) == escc_pkg::OP_TO_SECONDS)
                        ? ST_YEAR : ST_DIV;
          end
        end
        ST_DIV: begin
          case (dstage)
            DIV_DAY_Q: begin
              days   <= 25'(day_prod[50:35]);
              dstage <= DIV_DAY_R;
            end
            DIV_DAY_R: begin
              acc    <= alu_y;
              dstage <= DIV_HOUR_Q;
            end
            DIV_HOUR_Q: begin
              hour   <= hour_prod[25:21];
              dstage <= DIV_HOUR_R;
            end
            DIV_HOUR_R: begin
              acc    <= alu_y;
              dstage <= DIV_MIN_Q;
            end
            DIV_MIN_Q: begin
              minute <= min_prod[19:14];
              dstage <= DIV_MIN_R;
            end
            default: begin
              sec   <= alu_y[5:0];
              state <= ST_YEAR;
            end
          endcase
        end
        ST_YEAR: begin
          if ((op == escc_pkg::OP_TO_SECONDS) ? (year < in_year) : alu_ge) begin
            days <= alu_y[24:0];
            year <= year_inc;
            leap <= escc_pkg::is_leap(year_inc);
          end else begin
            state <= ST_MONTH;
          end
        end
        ST_MONTH: begin
          if (op == escc_pkg::OP_TO_SECONDS) begin
            if (month < in_month) begin
              days  <= alu_y[24:0];
              month <= month + 4'd1;
            end else begin
              state <= ST_DAYADD;
            end
          end else begin
            if (month < escc_pkg::MONTHS && alu_ge) begin
              days  <= alu_y[24:0];
              month <= month + 4'd1;
            end else begin
              day   <= days[4:0] + 5'd1;
              state <= ST_FIN;
            end
          end
        end
        ST_DAYADD: begin
          days  <= alu_y[24:0];
          state <= ST_MUL;
        end
        ST_MUL: begin
          acc   <= mul_full[31:0];
          state <= ST_SOD;
        end
        ST_SOD: begin
          acc   <= alu_y;
          state <= ST_FIN;
        end
        ST_FIN: begin
          // hold until the output register is free
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tdata  <= out_pack;
            m_axis_tvalid <= 1'b1;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_sod_below_day: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV && dstage == DIV_HOUR_Q |-> acc < 32'(escc_pkg::SEC_PER_DAY))
    else $error("seconds of day out of range");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken again right after an item");

  a_valid_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state) == ST_FIN)
    else $error("result raised outside the finish step");

  a_month_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_MONTH && op == escc_pkg::OP_TO_DATE
      |-> month >= 4'd1 && month <= escc_pkg::MONTHS)
    else $error("month out of range in count to date");

  a_year_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_YEAR && op == escc_pkg::OP_TO_DATE |-> year <= 12'd2106)
    else $error("year past the largest count");

endmodule

// ----- tb/epoch_seconds_calendar_converter_tb.sv -----
`timescale 1ns / 100ps

module epoch_seconds_calendar_converter_tb;

  localparam logic        OP_TO_DATE   = escc_pkg::OP_TO_DATE;
  localparam logic        OP_TO_COUNT  = escc_pkg::OP_TO_SECONDS;
  localparam int unsigned FIRST_YEAR   = 1970;
  localparam int unsigned DAY_SECONDS  = 86400;
  localparam int unsigned HOUR_SECONDS = 3600;

  // same layout on both sides, last field in the lowest bits
  typedef struct packed {
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [11:0] year;
    logic [31:0] seconds;
  } cal_fields_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // epoch_seconds[31:0], in_year[43:32], in_month[47:44], in_day[52:48],
  // in_hour[57:53], in_minute[63:58], in_second[69:64], zero[71:70]
  logic [71:0] s_axis_tdata = '0;
  // operation[0]
  logic [0:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // out_seconds[31:0], out_year[43:32], out_month[47:44], out_day[52:48],
  // out_hour[57:53], out_minute[63:58], out_second[69:64], zero[71:70]
  logic [71:0] m_axis_tdata;

  cal_fields_t awaited_results[$];
  int          mismatch_count = 0;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          hold_len       = 0;
  int          hold_seq       = 0;
  int          hold_seen      = 0;
  int          hold_left      = 0;

  epoch_seconds_calendar_converter i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit leap_year(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned days_in_year(input int unsigned y);
    return leap_year(y) ? 366 : 365;
  endfunction

  // months past July alternate the other way round, up to month 15
  function automatic int unsigned month_days(input int unsigned m, input int unsigned y);
    if (m == 2) begin
      return leap_year(y) ? 29 : 28;
    end
    if (m <= 7) begin
      return (m % 2 == 0) ? 30 : 31;
    end
    return (m % 2 == 0) ? 31 : 30;
  endfunction

  function automatic cal_fields_t convert_calendar(input logic op, input cal_fields_t rq);
    cal_fields_t res;
    int unsigned rest;
    int unsigned yr;
    int unsigned mo;
    int unsigned total;
    res = '0;
    if (op == OP_TO_DATE) begin
      rest = rq.seconds;
      res.second = 6'(rest % 60);
      rest = rest / 60;
      res.minute = 6'(rest % 60);
      rest = rest / 60;
      res.hour = 5'(rest % 24);
      rest = rest / 24;
      yr = FIRST_YEAR;
      while (rest >= days_in_year(yr)) begin
        rest -= days_in_year(yr);
        yr++;
      end
      mo = 1;
      while (mo < 12 && rest >= month_days(mo, yr)) begin
        rest -= month_days(mo, yr);
        mo++;
      end
      res.year  = 12'(yr);
      res.month = 4'(mo);
      res.day   = 5'(rest + 1);
    end else begin
      // every sum wraps at 32 bits; a year below 1970 or month 0 adds nothing
      total = 0;
      for (yr = FIRST_YEAR; yr < rq.year; yr++) begin
        total += days_in_year(yr) * DAY_SECONDS;
      end
      for (mo = 1; mo < rq.month; mo++) begin
        total += month_days(mo, rq.year) * DAY_SECONDS;
      end
      total += (32'(rq.day) - 32'd1) * DAY_SECONDS;
      total += 32'(rq.hour) * HOUR_SECONDS + 32'(rq.minute) * 32'd60 + 32'(rq.second);
      res.seconds = total;
    end
    return res;
  endfunction

  function automatic cal_fields_t make_date(input int y, input int mo, input int d,
                                            input int h, input int mi, input int s);
    cal_fields_t rq;
    rq = '0;
    rq.year   = 12'(y);
    rq.month  = 4'(mo);
    rq.day    = 5'(d);
    rq.hour   = 5'(h);
    rq.minute = 6'(mi);
    rq.second = 6'(s);
    return rq;
  endfunction

  // well-formed date in 1970..2106, leaving the count field random
  function automatic cal_fields_t random_valid_date();
    cal_fields_t rq;
    rq = {$urandom, $urandom, 6'($urandom)};
    rq.year   = 12'($urandom_range(1970, 2106));
    rq.month  = 4'($urandom_range(1, 12));
    rq.day    = 5'($urandom_range(1, month_days(rq.month, rq.year)));
    rq.hour   = 5'($urandom_range(23));
    rq.minute = 6'($urandom_range(59));
    rq.second = 6'($urandom_range(59));
    return rq;
  endfunction

  function automatic cal_fields_t random_request(input logic op);
    cal_fields_t rq;
    cal_fields_t near;
    int unsigned pick;
    rq   = {$urandom, $urandom, 6'($urandom)};
    pick = $urandom_range(99);
    if (op == OP_TO_DATE) begin
      // in 45 of 100 picks, land close to a month, year or day boundary
      if (pick < 45) begin
        near = random_valid_date();
        near.year = 12'($urandom_range(1970, 2105));
        if ($urandom_range(1)) begin
          near.day = 5'(month_days(near.month, near.year));
          near.hour = 5'd23;
          near.minute = 6'd59;
          near.second = 6'd59;
        end else begin
          near.day = 5'd1;
          near.hour = 5'd0;
          near.minute = 6'd0;
          near.second = 6'd0;
        end
        rq.seconds = convert_calendar(OP_TO_COUNT, near).seconds
                     + 32'($urandom_range(2)) - 32'd1;
      end
    end else begin
      rq = random_valid_date();
      if (pick < 6) begin
        rq.year = 12'($urandom_range(1969));
      end else if (pick < 12) begin
        rq.month = 4'($urandom_range(15));
      end else if (pick < 18) begin
        rq.day = 5'($urandom_range(31));
      end else if (pick < 26) begin
        rq.hour   = 5'($urandom_range(31));
        rq.minute = 6'($urandom_range(63));
        rq.second = 6'($urandom_range(63));
      end
    end
    return rq;
  endfunction

  function automatic void check_field(input string label, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, label, want, got);
      mismatch_count++;
    end
  endfunction

  task automatic send_request(input logic op, input cal_fields_t rq);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {2'b00, rq};
    @(posedge clk);
    while (!s_axis_tready) begin
      @(posedge clk);
    end
    awaited_results.push_back(convert_calendar(op, rq));
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (awaited_results.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic test_directed_cases();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_request(OP_TO_DATE, '0);
    send_request(OP_TO_DATE, cal_fields_t'({38'd0, 32'hFFFF_FFFF}));
    send_request(OP_TO_DATE, convert_calendar(OP_TO_COUNT, make_date(1972, 2, 29, 12, 0, 0)));
    send_request(OP_TO_DATE, convert_calendar(OP_TO_COUNT, make_date(2000, 2, 29, 0, 0, 0)));
    send_request(OP_TO_DATE, convert_calendar(OP_TO_COUNT, make_date(2000, 12, 31, 23, 59, 59)));
    send_request(OP_TO_DATE, convert_calendar(OP_TO_COUNT, make_date(2100, 2, 28, 23, 59, 59)));
    send_request(OP_TO_DATE, convert_calendar(OP_TO_COUNT, make_date(2100, 3, 1, 0, 0, 0)));
    send_request(OP_TO_COUNT, make_date(1970, 1, 1, 0, 0, 0));
    send_request(OP_TO_COUNT, make_date(2106, 2, 7, 6, 28, 15));
    // one second past the largest count wraps to zero
    send_request(OP_TO_COUNT, make_date(2106, 2, 7, 6, 28, 16));
    send_request(OP_TO_COUNT, make_date(0, 1, 1, 0, 0, 0));
    send_request(OP_TO_COUNT, make_date(1969, 12, 31, 23, 59, 59));
    send_request(OP_TO_COUNT, make_date(1999, 0, 15, 8, 30, 0));
    send_request(OP_TO_COUNT, make_date(2000, 15, 1, 0, 0, 0));
    send_request(OP_TO_COUNT, make_date(2100, 13, 2, 0, 0, 0));
    send_request(OP_TO_COUNT, make_date(1970, 1, 0, 0, 0, 0));
    send_request(OP_TO_COUNT, make_date(2024, 2, 31, 0, 0, 0));
    send_request(OP_TO_COUNT, make_date(1999, 12, 31, 31, 63, 63));
    send_request(OP_TO_COUNT, make_date(2000, 3, 1, 0, 0, 0));
    send_request(OP_TO_COUNT, make_date(4095, 15, 31, 31, 63, 63));
    drain_results();
  endtask

  task automatic test_random_mix(input int count, input int idle_pct, input int stall_pct);
    logic op;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) begin
      op = 1'($urandom_range(1));
      send_request(op, random_request(op));
    end
    drain_results();
  endtask

  // hold the output long enough that the block fills up and stops taking items
  task automatic test_output_hold_off();
    logic op;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_len = 1500;
    hold_seq++;
    repeat (30) begin
      op = 1'($urandom_range(1));
      send_request(op, random_request(op));
    end
    drain_results();
  endtask

  // years far past 2106 make the year loop long, so keep these few
  task automatic test_far_years();
    cal_fields_t rq;
    send_idle_pct  = 20;
    recv_stall_pct = 20;
    repeat (12) begin
      rq = random_request(OP_TO_COUNT);
      rq.year = 12'($urandom_range(2107, 4095));
      send_request(OP_TO_COUNT, rq);
    end
    drain_results();
  endtask

  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = hold_len;
    end
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : result_check
    cal_fields_t want;
    cal_fields_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[69:0];
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected item: expected none, actual tdata %h", $time, m_axis_tdata);
        mismatch_count++;
      end else begin
        want = awaited_results.pop_front();
        check_field("out_seconds", want.seconds, got.seconds);
        check_field("out_year", want.year, got.year);
        check_field("out_month", want.month, got.month);
        check_field("out_day", want.day, got.day);
        check_field("out_hour", want.hour, got.hour);
        check_field("out_minute", want.minute, got.minute);
        check_field("out_second", want.second, got.second);
        check_field("tdata padding", '0, m_axis_tdata[71:70]);
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_random_mix(350, 0, 0);
    test_random_mix(350, 68, 0);
    test_random_mix(350, 0, 68);
    test_random_mix(350, 35, 35);
    test_output_hold_off();
    test_far_years();
    // catch any stray item after the last one
    repeat (2500) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
